// File: hw/rtl/trz_pkg.sv
// ---------------------------------------------------------------------------
// trz_pkg
// shared sizes and codes of the triangle raster block
// ---------------------------------------------------------------------------
package trz_pkg;

  localparam int FB_WIDTH  = 256;
  localparam int FB_HEIGHT = 256;
  localparam int FB_DEPTH  = FB_WIDTH * FB_HEIGHT;
  localparam int ADDR_W    = $clog2(FB_DEPTH);

  localparam int CFG_W  = 9;
  localparam int IN_W   = 80;
  localparam int OUT_W  = 48;
  localparam int GRAY_W = 8;
  localparam int DEP_W  = 16;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_VERTEX = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
  localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

  localparam logic [DEP_W-1:0] FAR_DEPTH = 16'hFFFF;
  localparam logic [15:0]      LIGHT_ONE = 16'd16384;

endpackage

// File: hw/rtl/trz_ram.sv
// ---------------------------------------------------------------------------
// trz_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module trz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/triangle_raster_zbuffer_gouraud.sv
// ---------------------------------------------------------------------------
// triangle_raster_zbuffer_gouraud
// edge function triangle rasterizer with depth buffer and grey shading
//
// channel | direction | handshake              | payload
// in_     | slave     | in_tvalid / in_tready  | tdata vertex and read fields, tuser mode
// out_    | master    | out_tvalid / out_tready| tdata gray, depth, written, degenerate
// cfg_    | slave     | cfg_valid / cfg_ready  | cfg_addr register, cfg_data value
//
// one shared multiply-accumulate and one restoring divider run under the
// sequencer: an uncovered pixel stops after the edge tests, a covered one that
// loses the depth test after the depth divide, and a written pixel goes on
// through the light sum and the grey divide, after the triangle setup. a clear
// sweeps both rams; after reset the same sweep runs before the first request.
// a new request is taken while a result waits; the finish step waits for it.
// ---------------------------------------------------------------------------
module triangle_raster_zbuffer_gouraud (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // vertex_x, vertex_y, vertex_depth, normal_z, read_col, read_row
  input  logic [trz_pkg::IN_W-1:0]   in_tdata,
  // mode
  input  logic [1:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // pixel_gray, pixel_depth, pixels_written, degenerate, zero fill
  output logic [trz_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_addr,
  input  logic [trz_pkg::CFG_W-1:0]  cfg_data
);
  import trz_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_AREA0, S_AREA1, S_AREA2, S_BASE, S_PIX, S_DSTART,
    S_DIV, S_CMP, S_LMAC, S_GSTART, S_WR, S_NEXT, S_RMUL, S_RADDR, S_RREQ,
    S_RDATA, S_FIN
  } state_t;

  typedef enum logic [1:0] {MAC_HOLD, MAC_LOAD, MAC_ADD, MAC_SUB} mac_op_t;

  state_t state_r;
  logic [3:0] step_r;
  logic signed [15:0] hx_r [2];
  logic signed [15:0] hy_r [2];
  logic [15:0] hz_r [2];
  logic [14:0] hl_r [2];
  logic [1:0] vcnt_r;
  logic signed [15:0] v2x_r, v2y_r;
  logic [15:0] v2z_r;
  logic [14:0] v2l_r;
  logic [CFG_W-1:0] act_w_r, act_h_r;
  logic [7:0] xmin_r, xmax_r, ymin_r, ymax_r, x_r, y_r;
  logic box_empty_r;
  logic [ADDR_W-1:0] row_base_r, rd_addr_r, clr_cnt_r;
  logic signed [53:0] acc_r;
  logic [33:0] a_r;
  logic neg_r;
  logic signed [35:0] w0_r, w1_r, w2_r;
  logic [53:0] rem_r, dd_r;
  logic [15:0] q_r, z_r;
  logic [4:0] cnt_r;
  logic div_g_r;
  logic [16:0] pcount_r;
  logic degen_r, clr_out_r;
  logic [7:0] rc_r, rr_r;
  logic [GRAY_W-1:0] res_gray_r;
  logic [DEP_W-1:0] res_depth_r;
  logic out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [CFG_W-1:0] ew, eh;
  logic signed [15:0] vx0, vx1, vx2, vy0, vy1, vy2;
  logic signed [15:0] mnx, mxx, mny, mxy;
  logic signed [16:0] cx17, cy17;
  logic signed [13:0] fxmin, fxmax, fymin, fymax, ewm1, ehm1;
  logic signed [13:0] cxmin, cxmax, cymin, cymax;
  logic signed [16:0] px, py;
  mac_op_t mop;
  logic signed [35:0] ma;
  logic signed [16:0] mb;
  logic signed [52:0] prod;
  logic signed [53:0] acc_nxt, uacc;
  logic [ADDR_W-1:0] pix_addr, raddr, waddr;
  logic we;
  logic [GRAY_W-1:0] g_wdata, g_rdata;
  logic [DEP_W-1:0] d_wdata, d_rdata;
  logic [61:0] t255;
  logic signed [15:0] nz;
  logic [14:0] light;
  logic accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ew = (act_w_r > CFG_W'(FB_WIDTH)) ? CFG_W'(FB_WIDTH) : act_w_r;
  assign eh = (act_h_r > CFG_W'(FB_HEIGHT)) ? CFG_W'(FB_HEIGHT) : act_h_r;

  assign vx0 = hx_r[0];
  assign vx1 = hx_r[1];
  assign vx2 = v2x_r;
  assign vy0 = hy_r[0];
  assign vy1 = hy_r[1];
  assign vy2 = v2y_r;

  // bounding box
  always_comb begin
    mnx = (vx0 < vx1) ? vx0 : vx1;
    mnx = (mnx < vx2) ? mnx : vx2;
    mxx = (vx0 > vx1) ? vx0 : vx1;
    mxx = (mxx > vx2) ? mxx : vx2;
    mny = (vy0 < vy1) ? vy0 : vy1;
    mny = (mny < vy2) ? mny : vy2;
    mxy = (vy0 > vy1) ? vy0 : vy1;
    mxy = (mxy > vy2) ? mxy : vy2;
    cx17 = 17'(mxx) + 17'sd15;
    cy17 = 17'(mxy) + 17'sd15;
    fxmin = 14'(mnx >>> 4);
    fymin = 14'(mny >>> 4);
    fxmax = 14'(cx17 >>> 4);
    fymax = 14'(cy17 >>> 4);
    ewm1 = $signed({5'b0, ew}) - 14'sd1;
    ehm1 = $signed({5'b0, eh}) - 14'sd1;
    cxmin = (fxmin < 14'sd0) ? 14'sd0 : fxmin;
    cymin = (fymin < 14'sd0) ? 14'sd0 : fymin;
    cxmax = (fxmax > ewm1) ? ewm1 : fxmax;
    cymax = (fymax > ehm1) ? ehm1 : fymax;
  end

  assign px = $signed({5'b0, x_r, 4'b1000});
  assign py = $signed({5'b0, y_r, 4'b1000});

  // shared multiply-accumulate operand select
  always_comb begin
    mop = MAC_HOLD;
    ma  = '0;
    mb  = '0;
    unique case (state_r)
      S_AREA0: begin
        mop = MAC_LOAD;
        ma = 36'(17'(vx2) - 17'(vx0));
        mb = 17'(vy1) - 17'(vy0);
      end
      S_AREA1: begin
        mop = MAC_SUB;
        ma = 36'(17'(vy2) - 17'(vy0));
        mb = 17'(vx1) - 17'(vx0);
      end
      S_AREA2: begin
        mop = MAC_LOAD;
        ma = $signed({28'b0, ymin_r});
        mb = $signed({8'b0, ew});
      end
      S_RMUL: begin
        mop = MAC_LOAD;
        ma = $signed({28'b0, rr_r});
        mb = $signed({8'b0, ew});
      end
      S_PIX: begin
        case (step_r)
          4'd0: begin
            mop = MAC_LOAD;
            ma = 36'(px - 17'(vx1));
            mb = 17'(vy2) - 17'(vy1);
          end
          4'd1: begin
            mop = MAC_SUB;
            ma = 36'(py - 17'(vy1));
            mb = 17'(vx2) - 17'(vx1);
          end
          4'd2: begin
            mop = MAC_LOAD;
            ma = 36'(px - 17'(vx2));
            mb = 17'(vy0) - 17'(vy2);
          end
          4'd3: begin
            mop = MAC_SUB;
            ma = 36'(py - 17'(vy2));
            mb = 17'(vx0) - 17'(vx2);
          end
          4'd4: begin
            mop = MAC_LOAD;
            ma = 36'(px - 17'(vx0));
            mb = 17'(vy1) - 17'(vy0);
          end
          4'd5: begin
            mop = MAC_SUB;
            ma = 36'(py - 17'(vy0));
            mb = 17'(vx1) - 17'(vx0);
          end
          4'd6: begin
            mop = MAC_LOAD;
            ma = w0_r;
            mb = $signed({1'b0, hz_r[0]});
          end
          4'd7: begin
            mop = MAC_ADD;
            ma = w1_r;
            mb = $signed({1'b0, hz_r[1]});
          end
          default: begin
            mop = MAC_ADD;
            ma = w2_r;
            mb = $signed({1'b0, v2z_r});
          end
        endcase
      end
      S_LMAC: begin
        case (step_r)
          4'd0: begin
            mop = MAC_LOAD;
            ma = w0_r;
            mb = $signed({2'b0, hl_r[0]});
          end
          4'd1: begin
            mop = MAC_ADD;
            ma = w1_r;
            mb = $signed({2'b0, hl_r[1]});
          end
          default: begin
            mop = MAC_ADD;
            ma = w2_r;
            mb = $signed({2'b0, v2l_r});
          end
        endcase
      end
      default: mop = MAC_HOLD;
    endcase
  end

  always_comb begin
    prod = 53'(ma) * 53'(mb);
    case (mop)
      MAC_LOAD: acc_nxt = 54'(prod);
      MAC_ADD:  acc_nxt = acc_r + 54'(prod);
      MAC_SUB:  acc_nxt = acc_r - 54'(prod);
      default:  acc_nxt = acc_r;
    endcase
  end

  assign uacc     = neg_r ? -acc_r : acc_r;
  assign t255     = {8'b0, acc_r} * 62'd255;
  assign pix_addr = row_base_r + {{(ADDR_W-8){1'b0}}, x_r};

  assign nz    = $signed(in_tdata[63:48]);
  assign light = nz[15] ? 15'd0 :
                 (nz > $signed(LIGHT_ONE)) ? LIGHT_ONE[14:0] : nz[14:0];

  always_comb begin
    we      = (state_r == S_CLR) || (state_r == S_WR);
    waddr   = (state_r == S_CLR) ? clr_cnt_r : pix_addr;
    g_wdata = (state_r == S_CLR) ? '0 : q_r[7:0];
    d_wdata = (state_r == S_CLR) ? FAR_DEPTH : z_r;
    raddr   = (state_r == S_RREQ) ? rd_addr_r : pix_addr;
  end

  trz_ram #(.WIDTH(GRAY_W), .DEPTH(FB_DEPTH)) u_gray_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(g_wdata), .raddr(raddr), .rdata(g_rdata)
  );

  trz_ram #(.WIDTH(DEP_W), .DEPTH(FB_DEPTH)) u_depth_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(d_wdata), .raddr(raddr), .rdata(d_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      step_r      <= '0;
      clr_cnt_r   <= '0;
      clr_out_r   <= 1'b0;
      vcnt_r      <= '0;
      hx_r[0]     <= '0;
      hx_r[1]     <= '0;
      hy_r[0]     <= '0;
      hy_r[1]     <= '0;
      hz_r[0]     <= '0;
      hz_r[1]     <= '0;
      hl_r[0]     <= '0;
      hl_r[1]     <= '0;
      act_w_r     <= CFG_W'(256);
      act_h_r     <= CFG_W'(256);
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_addr)
          CFG_ACTIVE_WIDTH:  act_w_r <= cfg_data;
          CFG_ACTIVE_HEIGHT: act_h_r <= cfg_data;
        endcase
      end
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            state_r <= clr_out_r ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_gray_r  <= '0;
            res_depth_r <= '0;
            pcount_r    <= '0;
            degen_r     <= 1'b0;
            case (in_tuser)
              MODE_CLEAR: begin
                clr_cnt_r <= '0;
                clr_out_r <= 1'b1;
                state_r   <= S_CLR;
              end
              MODE_VERTEX: begin
                if (vcnt_r < 2'd2) begin
                  hx_r[vcnt_r[0]] <= $signed(in_tdata[15:0]);
                  hy_r[vcnt_r[0]] <= $signed(in_tdata[31:16]);
                  hz_r[vcnt_r[0]] <= in_tdata[47:32];
                  hl_r[vcnt_r[0]] <= light;
                  vcnt_r  <= vcnt_r + 2'd1;
                  state_r <= S_FIN;
                end else begin
                  v2x_r   <= $signed(in_tdata[15:0]);
                  v2y_r   <= $signed(in_tdata[31:16]);
                  v2z_r   <= in_tdata[47:32];
                  v2l_r   <= light;
                  vcnt_r  <= '0;
                  state_r <= S_AREA0;
                end
              end
              MODE_READ: begin
                rc_r <= in_tdata[71:64];
                rr_r <= in_tdata[79:72];
                if ({1'b0, in_tdata[71:64]} < ew && {1'b0, in_tdata[79:72]} < eh) begin
                  state_r <= S_RMUL;
                end else begin
                  state_r <= S_FIN;
                end
              end
              default: state_r <= S_FIN;
            endcase
          end
        end
        S_AREA0: begin
          xmin_r      <= cxmin[7:0];
          xmax_r      <= cxmax[7:0];
          ymin_r      <= cymin[7:0];
          ymax_r      <= cymax[7:0];
          box_empty_r <= (cxmin > cxmax) || (cymin > cymax);
          state_r     <= S_AREA1;
        end
        S_AREA1: state_r <= S_AREA2;
        S_AREA2: begin
          a_r   <= acc_r[53] ? 34'(-acc_r) : acc_r[33:0];
          neg_r <= acc_r[53];
          x_r   <= xmin_r;
          y_r   <= ymin_r;
          if (acc_r == '0) begin
            degen_r <= 1'b1;
            state_r <= S_FIN;
          end else if (box_empty_r) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          row_base_r <= acc_r[ADDR_W-1:0];
          step_r     <= '0;
          state_r    <= S_PIX;
        end
        S_PIX: begin
          step_r <= step_r + 4'd1;
          case (step_r)
            4'd2: w0_r <= uacc[35:0];
            4'd4: w1_r <= uacc[35:0];
            4'd6: begin
              w2_r <= uacc[35:0];
              if (w0_r[35] || w1_r[35] || uacc[35]) begin
                state_r <= S_NEXT;
              end
            end
            4'd8: state_r <= S_DSTART;
            default: ;
          endcase
        end
        S_DSTART: begin
          rem_r   <= acc_r;
          dd_r    <= 54'(a_r) << 15;
          cnt_r   <= 5'd16;
          q_r     <= '0;
          div_g_r <= 1'b0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (rem_r >= dd_r) begin
            rem_r <= rem_r - dd_r;
            q_r   <= {q_r[14:0], 1'b1};
          end else begin
            q_r   <= {q_r[14:0], 1'b0};
          end
          dd_r  <= dd_r >> 1;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            state_r <= div_g_r ? S_WR : S_CMP;
          end
        end
        S_CMP: begin
          z_r    <= q_r;
          step_r <= '0;
          state_r <= (q_r < d_rdata) ? S_LMAC : S_NEXT;
        end
        S_LMAC: begin
          step_r <= step_r + 4'd1;
          if (step_r == 4'd2) begin
            state_r <= S_GSTART;
          end
        end
        S_GSTART: begin
          rem_r   <= 54'(t255[61:14]);
          dd_r    <= 54'(a_r) << 7;
          cnt_r   <= 5'd8;
          q_r     <= '0;
          div_g_r <= 1'b1;
          state_r <= S_DIV;
        end
        S_WR: begin
          pcount_r <= pcount_r + 17'd1;
          state_r  <= S_NEXT;
        end
        S_NEXT: begin
          step_r <= '0;
          if (x_r == xmax_r) begin
            if (y_r == ymax_r) begin
              state_r <= S_FIN;
            end else begin
              x_r        <= xmin_r;
              y_r        <= y_r + 8'd1;
              row_base_r <= row_base_r + ADDR_W'(ew);
              state_r    <= S_PIX;
            end
          end else begin
            x_r     <= x_r + 8'd1;
            state_r <= S_PIX;
          end
        end
        S_RMUL: state_r <= S_RADDR;
        S_RADDR: begin
          rd_addr_r <= acc_r[ADDR_W-1:0] + {{(ADDR_W-8){1'b0}}, rc_r};
          state_r   <= S_RREQ;
        end
        S_RREQ: state_r <= S_RDATA;
        S_RDATA: begin
          res_gray_r  <= g_rdata;
          res_depth_r <= d_rdata;
          state_r     <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {6'b0, degen_r, pcount_r, res_depth_r, res_gray_r};
            out_valid_r <= 1'b1;
            clr_out_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: verif/tb_triangle_raster_zbuffer_gouraud.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_triangle_raster_zbuffer_gouraud
// self-checking bench for the triangle rasterizer with depth and grey stores
//
// a predictor keeps its own grey and depth stores, held vertices and active
// size, and computes the expected result of every accepted request. a checker
// compares each result field by field. directed tests cover reset contents,
// both windings, zero area, light saturation, clipping, reads outside the
// active area, the unused mode and clears; random phases then run at several
// active sizes with random gaps on the request side and stalls on the result
// side.
// ---------------------------------------------------------------------------
module tb_triangle_raster_zbuffer_gouraud;
  import trz_pkg::*;

  localparam int WATCHDOG_LIMIT = 12000000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         mode;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [15:0]        vz;
    logic signed [15:0] nz;
    logic [7:0]         col;
    logic [7:0]         row;
  } raster_req_t;

  typedef struct {
    logic [7:0]  gray;
    logic [15:0] depth;
    logic [16:0] written;
    logic        degen;
  } raster_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic [1:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_addr = 1'b0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state
  logic [7:0]           gray_mem [FB_DEPTH];
  logic [15:0]          depth_mem [FB_DEPTH];
  longint               hold_x [2], hold_y [2], hold_z [2], hold_l [2];
  int                   held_cnt;
  int                   act_w, act_h;

  raster_res_t          pending_res [$];
  int                   errors = 0;
  int                   wd_count = 0;
  bit                   no_idle = 1'b0;
  int                   n_tri = 0, n_degen = 0, n_read = 0, n_clear = 0;
  longint               n_pix = 0;
  int                   ox, oy;

  triangle_raster_zbuffer_gouraud dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
    return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
  endfunction

  function automatic int eff_w();
    return act_w > FB_WIDTH ? FB_WIDTH : act_w;
  endfunction

  function automatic int eff_h();
    return act_h > FB_HEIGHT ? FB_HEIGHT : act_h;
  endfunction

  function automatic void wipe_stores();
    for (int i = 0; i < FB_DEPTH; i++) begin
      gray_mem[i] = '0;
      depth_mem[i] = FAR_DEPTH;
    end
  endfunction

  function automatic raster_res_t predict_raster(raster_req_t r);
    raster_res_t res;
    longint x[3], y[3], z[3], l[3];
    longint xmin, xmax, ymin, ymax, area, w0, w1, w2, a, zz, g, px, py, lt;
    int ew, eh, idx;
    res = '{default: '0};
    ew = eff_w();
    eh = eff_h();
    case (r.mode)
      MODE_CLEAR: wipe_stores();
      MODE_VERTEX: begin
        lt = longint'(r.nz);
        if (lt < 0) lt = 0;
        if (lt > LIGHT_ONE) lt = LIGHT_ONE;
        if (held_cnt < 2) begin
          hold_x[held_cnt] = longint'(r.vx);
          hold_y[held_cnt] = longint'(r.vy);
          hold_z[held_cnt] = longint'(r.vz);
          hold_l[held_cnt] = lt;
          held_cnt++;
        end else begin
          held_cnt = 0;
          for (int k = 0; k < 2; k++) begin
            x[k] = hold_x[k]; y[k] = hold_y[k]; z[k] = hold_z[k]; l[k] = hold_l[k];
          end
          x[2] = longint'(r.vx); y[2] = longint'(r.vy); z[2] = longint'(r.vz); l[2] = lt;
          n_tri++;
          xmin = x[0]; xmax = x[0]; ymin = y[0]; ymax = y[0];
          for (int k = 1; k < 3; k++) begin
            if (x[k] < xmin) xmin = x[k];
            if (x[k] > xmax) xmax = x[k];
            if (y[k] < ymin) ymin = y[k];
            if (y[k] > ymax) ymax = y[k];
          end
          xmin = xmin >>> 4;
          ymin = ymin >>> 4;
          xmax = -((-xmax) >>> 4);
          ymax = -((-ymax) >>> 4);
          if (xmin < 0) xmin = 0;
          if (ymin < 0) ymin = 0;
          if (xmax > ew - 1) xmax = ew - 1;
          if (ymax > eh - 1) ymax = eh - 1;
          area = edge_fn(x[0], y[0], x[1], y[1], x[2], y[2]);
          if (area == 0) begin
            res.degen = 1'b1;
            n_degen++;
          end else begin
            for (longint yy = ymin; yy <= ymax; yy++) begin
              for (longint xx = xmin; xx <= xmax; xx++) begin
                px = xx * 16 + 8;
                py = yy * 16 + 8;
                w0 = edge_fn(x[1], y[1], x[2], y[2], px, py);
                w1 = edge_fn(x[2], y[2], x[0], y[0], px, py);
                w2 = edge_fn(x[0], y[0], x[1], y[1], px, py);
                if ((w0 >= 0 && w1 >= 0 && w2 >= 0) || (w0 <= 0 && w1 <= 0 && w2 <= 0)) begin
                  a = area;
                  if (area < 0) begin
                    a = -area; w0 = -w0; w1 = -w1; w2 = -w2;
                  end
                  zz = (w0 * z[0] + w1 * z[1] + w2 * z[2]) / a;
                  if (zz > FAR_DEPTH) zz = FAR_DEPTH;
                  idx = int'(yy * ew + xx);
                  if (zz < depth_mem[idx]) begin
                    depth_mem[idx] = zz[15:0];
                    g = ((w0 * l[0] + w1 * l[1] + w2 * l[2]) * 255) / (a * LIGHT_ONE);
                    if (g > 255) g = 255;
                    gray_mem[idx] = g[7:0];
                    res.written++;
                  end
                end
              end
            end
            n_pix += res.written;
          end
        end
      end
      MODE_READ: begin
        n_read++;
        if (r.col < ew && r.row < eh) begin
          idx = r.row * ew + r.col;
          res.gray = gray_mem[idx];
          res.depth = depth_mem[idx];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_req(raster_req_t r);
    int gap;
    gap = 0;
    if (!no_idle)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {r.row, r.col, r.nz, r.vz, r.vy, r.vx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_res.push_back(predict_raster(r));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ACTIVE_WIDTH) act_w = value & 9'h1FF;
    else act_h = value & 9'h1FF;
  endtask

  task automatic set_size(int w, int h);
    write_reg(CFG_ACTIVE_WIDTH, w);
    write_reg(CFG_ACTIVE_HEIGHT, h);
  endtask

  function automatic raster_req_t mk(logic [1:0] m, int x = 0, int y = 0, int z = 0,
                                     int n = 0, int c = 0, int rw = 0);
    raster_req_t r;
    r.mode = m; r.vx = x[15:0]; r.vy = y[15:0]; r.vz = z[15:0]; r.nz = n[15:0];
    r.col = c[7:0]; r.row = rw[7:0];
    return r;
  endfunction

  task automatic test_reset_contents();
    send_req(mk(MODE_READ, 0, 0, 0, 0, 0, 0));
    send_req(mk(MODE_READ, 0, 0, 0, 0, 255, 255));
  endtask

  task automatic test_shading();
    // counter-clockwise, light full, negative and saturated
    send_req(mk(MODE_VERTEX, 2 * 16, 2 * 16, 0, 16384));
    send_req(mk(MODE_VERTEX, 12 * 16, 3 * 16 + 5, 65535, -5));
    send_req(mk(MODE_READ, 0, 0, 0, 0, 5, 5));
    send_req(mk(MODE_VERTEX, 5 * 16 + 3, 11 * 16, 30000, 20000));
    send_req(mk(MODE_READ, 0, 0, 0, 0, 5, 5));
    // opposite winding, partly nearer
    send_req(mk(MODE_VERTEX, 3 * 16, 10 * 16, 100, 8000));
    send_req(mk(MODE_VERTEX, 10 * 16, 10 * 16, 40000, 16383));
    send_req(mk(MODE_VERTEX, 6 * 16, 1 * 16, 20000, 32767));
    send_req(mk(MODE_READ, 0, 0, 0, 0, 6, 7));
    // collinear vertices
    send_req(mk(MODE_VERTEX, 16, 16, 5, 100));
    send_req(mk(MODE_VERTEX, 48, 48, 5, 100));
    send_req(mk(MODE_VERTEX, 96, 96, 5, 100));
    send_req(mk(MODE_UNUSED, -1, -1, 65535, -1, 255, 255));
  endtask

  task automatic test_clip();
    set_size(16, 16);
    send_req(mk(MODE_VERTEX, -32768, -32768, 65535, -32768));
    send_req(mk(MODE_VERTEX, 32767, -32768, 0, 16384));
    send_req(mk(MODE_VERTEX, 0, 32767, 1234, 9000));
    send_req(mk(MODE_READ, 0, 0, 0, 0, 15, 15));
    send_req(mk(MODE_READ, 0, 0, 0, 0, 200, 3));
    send_req(mk(MODE_READ, 0, 0, 0, 0, 3, 16));
  endtask

  task automatic test_clear();
    send_req(mk(MODE_CLEAR));
    send_req(mk(MODE_READ, 0, 0, 0, 0, 4, 4));
  endtask

  function automatic raster_req_t rand_req();
    raster_req_t r;
    int p, ew, eh;
    bit wide;
    ew = eff_w();
    eh = eff_h();
    wide = (ew * eh <= 1024);
    p = $urandom_range(0, 99);
    r = mk(MODE_READ);
    r.vx = 16'($urandom); r.vy = 16'($urandom); r.vz = 16'($urandom); r.nz = 16'($urandom);
    r.col = 8'($urandom); r.row = 8'($urandom);
    if (p < 2) begin
      r.mode = MODE_CLEAR;
    end else if (p < 6) begin
      r.mode = MODE_UNUSED;
    end else if (p < 30) begin
      if ($urandom_range(0, 4) != 0) begin
        r.col = 8'(wide ? $urandom_range(0, ew + 1 > 255 ? 255 : ew + 1)
                        : (ox / 16 + $urandom_range(0, 16)));
        r.row = 8'(wide ? $urandom_range(0, eh + 1 > 255 ? 255 : eh + 1)
                        : (oy / 16 + $urandom_range(0, 16)));
      end
    end else begin
      r.mode = MODE_VERTEX;
      if (held_cnt == 0) begin
        ox = $urandom_range(0, 255 * 16) - 64;
        oy = $urandom_range(0, 255 * 16) - 64;
      end
      if (!wide || $urandom_range(0, 9) < 7) begin
        if (wide) begin
          r.vx = 16'($urandom_range(0, (ew + 4) * 16) - 32);
          r.vy = 16'($urandom_range(0, (eh + 4) * 16) - 32);
        end else begin
          r.vx = 16'(ox + $urandom_range(0, 16 * 16));
          r.vy = 16'(oy + $urandom_range(0, 16 * 16));
        end
      end
      if (held_cnt == 2 && $urandom_range(0, 9) == 0) begin
        r.vx = 16'(hold_x[0]);
        r.vy = 16'(hold_y[0]);
      end
      if ($urandom_range(0, 9) < 7) r.nz = 16'($urandom_range(0, 16384));
    end
    return r;
  endfunction

  task automatic test_random_sizes();
    int sizes [6][2] = '{'{256, 256}, '{16, 16}, '{1, 256}, '{256, 1}, '{5, 37}, '{1, 1}};
    for (int s = 0; s < 6; s++) begin
      set_size(sizes[s][0], sizes[s][1]);
      no_idle = (s == 3);
      for (int i = 0; i < 12; i++) send_req(rand_req());
    end
    no_idle = 1'b0;
    set_size(256, 256);
    for (int i = 0; i < 8; i++) send_req(rand_req());
  endtask

  // result side stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (no_idle) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= $urandom_range(0, 3) != 0;
      stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(15, 50);
    end
  end

  always @(posedge clk) begin
    raster_res_t e;
    if (out_tvalid && out_tready) begin
      if (pending_res.size() == 0) begin
        $error("result with no request pending: %h", out_tdata);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (out_tdata[7:0] !== e.gray) begin
          $error("pixel_gray expected %0d actual %0d", e.gray, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[23:8] !== e.depth) begin
          $error("pixel_depth expected %0d actual %0d", e.depth, out_tdata[23:8]);
          errors++;
        end
        if (out_tdata[40:24] !== e.written) begin
          $error("pixels_written expected %0d actual %0d", e.written, out_tdata[40:24]);
          errors++;
        end
        if (out_tdata[41] !== e.degen) begin
          $error("degenerate expected %0d actual %0d", e.degen, out_tdata[41]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      wd_count <= 0;
    else
      wd_count <= wd_count + 1;
    if (wd_count >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_res.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    wipe_stores();
    held_cnt = 0;
    act_w = 256;
    act_h = 256;
    for (int k = 0; k < 2; k++) begin
      hold_x[k] = 0; hold_y[k] = 0; hold_z[k] = 0; hold_l[k] = 0;
    end
    ox = 0;
    oy = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_contents();
    test_shading();
    test_clip();
    test_clear();
    test_random_sizes();
    drain();
    $display("covered %0d triangles (%0d zero area, %0d pixels drawn), %0d reads",
             n_tri, n_degen, n_pix, n_read);
    $display("active sizes from 1x1 to 256x256 with gaps and result stalls");
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/trz_pkg.sv
hw/rtl/trz_ram.sv
hw/rtl/triangle_raster_zbuffer_gouraud.sv
verif/tb_triangle_raster_zbuffer_gouraud.sv
